// ----- src/svt_pkg.sv -----
package svt_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 5;

    typedef struct packed {
        logic ins_en;
        logic del_en;
    } t_cell_ctl;

endpackage

// ----- src/svt_cell.sv -----
module svt_cell (
    input  logic                                    i_clk,
    input  svt_pkg::t_cell_ctl                      i_ctl,
    input  logic                                    i_occ,
    input  logic signed [svt_pkg::VALUE_W-1:0]      i_key,
    input  logic signed [svt_pkg::VALUE_W-1:0]      i_left_value,
    input  logic signed [svt_pkg::VALUE_W-1:0]      i_right_value,
    input  logic                                    i_left_lt,
    output logic signed [svt_pkg::VALUE_W-1:0]      o_value,
    output logic                                    o_lt,
    output logic                                    o_eq,
    output logic                                    o_boundary
);
    import svt_pkg::*;

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;

    assign o_value    = r_value;
    assign o_lt       = i_occ && (r_value < i_key);
    assign o_eq       = i_occ && (r_value == i_key);
    // first cell whose entry is not below the key (or first free cell)
    assign o_boundary = !o_lt && i_left_lt;

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins_en && !o_lt) begin
            n_value = i_left_lt ? i_key : i_left_value;
        end else if (i_ctl.del_en && !o_lt) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

// ----- src/sorted_value_table_unit.sv -----
// Sorted value table: keeps up to DEPTH signed 32-bit values in ascending
// order in a row of cells that compare against the item's value in parallel
// and shift toward their neighbors on insert or delete. o_busy stays low, so
// an item is accepted in every cycle that i_start is high; its result appears
// on the o_ ports for exactly one cycle with o_strobe, in the cycle after the
// item, with no way for the receiver to stall it. Position and count are
// reported modulo 32. The critical path is the 32-bit compare in each cell
// followed by the position/match reduction across the row.
module sorted_value_table_unit #(
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [1:0]                          i_operation,
    input  logic signed [svt_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_busy,
    output logic                                o_strobe,
    output logic [1:0]                          o_status,
    output logic [svt_pkg::POS_W-1:0]           o_position,
    output logic [svt_pkg::POS_W-1:0]           o_count,
    output logic                                o_empty_res
);
    import svt_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic                     r_strobe;
    logic [1:0]               r_status;
    logic [1:0]               n_status;
    logic [POS_W-1:0]         r_position;
    logic [POS_W-1:0]         n_position;

    logic                     accept;
    t_op                      op;
    t_cell_ctl                ctl;
    logic                     full;
    logic                     found;
    logic [CW-1:0]            hit_pos;
    logic [EW-1:0]            pos_wide;
    logic [EW-1:0]            cnt_wide;

    logic [DEPTH-1:0]         occ;
    logic [DEPTH-1:0]         lt;
    logic [DEPTH-1:0]         eq;
    logic [DEPTH-1:0]         bnd;
    logic [DEPTH:0]           left_lt;
    logic signed [VALUE_W-1:0] cell_value [DEPTH];

    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;
    assign op     = t_op'(i_operation);
    assign full   = (r_count == CW'(DEPTH));

    assign left_lt[0] = 1'b1;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign occ[g]       = (CW'(g) < r_count);
        assign left_lt[g+1] = lt[g];

        svt_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_occ         (occ[g]),
            .i_key         (i_value),
            .i_left_value  ((g == 0) ? i_value : cell_value[(g == 0) ? 0 : g-1]),
            .i_right_value ((g == DEPTH-1) ? cell_value[g]
                                           : cell_value[(g == DEPTH-1) ? g : g+1]),
            .i_left_lt     (left_lt[g]),
            .o_value       (cell_value[g]),
            .o_lt          (lt[g]),
            .o_eq          (eq[g]),
            .o_boundary    (bnd[g])
        );
    end

    always_comb begin
        found   = 1'b0;
        hit_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            found   = found | (bnd[i] & eq[i]);
            hit_pos = hit_pos | (bnd[i] ? CW'(i + 1) : '0);
        end
    end

    assign pos_wide = EW'(hit_pos);

    always_comb begin
        ctl.ins_en = 1'b0;
        ctl.del_en = 1'b0;
        n_count    = r_count;
        n_status   = ST_DONE;
        n_position = '0;
        if (accept) begin
            case (op)
                OP_INSERT: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        ctl.ins_en = 1'b1;
                        n_count    = r_count + CW'(1);
                    end
                end
                OP_DELETE: begin
                    if (found) begin
                        ctl.del_en = 1'b1;
                        n_count    = r_count - CW'(1);
                    end else begin
                        n_status = ST_NOTFOUND;
                    end
                end
                OP_SEARCH: begin
                    if (found) begin
                        n_position = pos_wide[POS_W-1:0];
                    end else begin
                        n_status = ST_NOTFOUND;
                    end
                end
                OP_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_position <= n_position;
    end

    assign cnt_wide    = EW'(r_count);
    assign o_strobe    = r_strobe;
    assign o_status    = r_status;
    assign o_position  = r_position;
    assign o_count     = cnt_wide[POS_W-1:0];
    assign o_empty_res = (r_count == '0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond table depth");

    a_strobe_follows_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_strobe)
        else $error("item accepted without a result");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !o_strobe)
        else $error("result without an item");

    a_full_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_FULL) |-> (r_count == CW'(DEPTH)))
        else $error("insert refused while table not full");

endmodule

// ----- tb/sv/tb_sorted_value_table_unit.sv -----
module tb_sorted_value_table_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import svt_pkg::*;

    localparam int DEPTH       = 16;
    localparam int NUM_RANDOM  = 635;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        t_op                 op;
        logic signed [31:0]  value;
    } t_table_req;

    typedef struct {
        logic [1:0]  status;
        logic [4:0]  position;
        logic [4:0]  count;
        logic        empty;
    } t_table_res;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_start     = 1'b0;
    logic [1:0]          i_operation = OP_SEARCH;
    logic signed [31:0]  i_value     = '0;
    logic                o_busy;
    logic                o_strobe;
    logic [1:0]          o_status;
    logic [4:0]          o_position;
    logic [4:0]          o_count;
    logic                o_empty_res;

    t_table_req          pending_items[$];
    t_table_res          expected_results[$];
    logic signed [31:0]  shadow_vals[DEPTH];
    int                  shadow_len   = 0;
    int                  fail_count   = 0;
    int                  cycle_count  = 0;
    int                  idle_left    = 0;
    int                  quiet_left   = 0;
    logic                item_taken   = 1'b0;
    logic signed [31:0]  value_pool[6];

    sorted_value_table_unit #(
        .DEPTH (DEPTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_operation (i_operation),
        .i_value     (i_value),
        .o_busy      (o_busy),
        .o_strobe    (o_strobe),
        .o_status    (o_status),
        .o_position  (o_position),
        .o_count     (o_count),
        .o_empty_res (o_empty_res)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Table update for one item; returns the result it should produce.
    function automatic t_table_res predict_table_op(t_op op, logic signed [31:0] value);
        t_table_res res;
        int slot;
        int hit;
        int k;
        res.status   = ST_DONE;
        res.position = '0;
        hit = shadow_len;
        for (k = shadow_len - 1; k >= 0; k--) begin
            if (shadow_vals[k] == value) begin
                hit = k;
            end
        end
        case (op)
            OP_INSERT: begin
                if (shadow_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    slot = 0;
                    while (slot < shadow_len && shadow_vals[slot] < value) begin
                        slot++;
                    end
                    for (k = shadow_len; k > slot; k--) begin
                        shadow_vals[k] = shadow_vals[k-1];
                    end
                    shadow_vals[slot] = value;
                    shadow_len++;
                end
            end
            OP_DELETE: begin
                if (hit >= shadow_len) begin
                    res.status = ST_NOTFOUND;
                end else begin
                    for (k = hit; k + 1 < shadow_len; k++) begin
                        shadow_vals[k] = shadow_vals[k+1];
                    end
                    shadow_len--;
                end
            end
            OP_SEARCH: begin
                if (hit >= shadow_len) begin
                    res.status = ST_NOTFOUND;
                end else begin
                    res.position = 5'(hit + 1);
                end
            end
            default: begin
                shadow_len = 0;
            end
        endcase
        res.count = 5'(shadow_len);
        res.empty = (shadow_len == 0);
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 3) begin
            quiet_left = $urandom_range(60, 20);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 96) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 45) return value_pool[$urandom_range(5)];
        if (r < 55) begin
            case ($urandom_range(4))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 32'sh0;
                3: return -32'sd1;
                default: return 32'sd1;
            endcase
        end
        if (r < 75) return $signed(32'($urandom_range(40))) - 32'sd20;
        return $signed($urandom);
    endfunction

    task automatic add_item(t_op op, logic signed [31:0] value);
        t_table_req req;
        req.op    = op;
        req.value = value;
        pending_items.push_back(req);
    endtask

    // driver: hold an item until taken, then idle or present the next one
    always @(negedge i_clk) begin
        t_table_req req;
        logic nxt_start;
        logic [1:0] nxt_op;
        logic signed [31:0] nxt_val;
        nxt_start = i_start;
        nxt_op    = i_operation;
        nxt_val   = i_value;
        if (i_rst_n && (!i_start || item_taken)) begin
            nxt_start = 1'b0;
            nxt_op    = 2'($urandom_range(3));
            nxt_val   = $signed($urandom);
            if (idle_left > 0) begin
                idle_left--;
            end else if (pending_items.size() > 0) begin
                req       = pending_items.pop_front();
                nxt_start = 1'b1;
                nxt_op    = req.op;
                nxt_val   = req.value;
                idle_left = pick_gap();
            end
        end
        i_start     <= nxt_start;
        i_operation <= nxt_op;
        i_value     <= nxt_val;
    end

    // monitor: check the result of the previous item, then predict the current one
    always @(posedge i_clk) begin
        t_table_res want;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (expected_results.size() == 0) begin
                    note_mismatch("result with no item pending", 32'd1, 32'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_status !== want.status)
                        note_mismatch("status", 32'(o_status), 32'(want.status));
                    if (o_position !== want.position)
                        note_mismatch("position", 32'(o_position), 32'(want.position));
                    if (o_count !== want.count)
                        note_mismatch("count", 32'(o_count), 32'(want.count));
                    if (o_empty_res !== want.empty)
                        note_mismatch("empty", 32'(o_empty_res), 32'(want.empty));
                end
            end
            if (i_start && !o_busy) begin
                expected_results.push_back(predict_table_op(t_op'(i_operation), i_value));
            end
            item_taken <= i_start && !o_busy;
        end else begin
            item_taken <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int made;
        int phase_len;
        int phase_kind;
        int r;
        int k;
        int w_ins;
        int w_del;
        int w_srch;
        t_op op;

        // directed: empty table, extremes, duplicates, misses, clear
        add_item(OP_SEARCH, 32'sd5);
        add_item(OP_DELETE, 32'sd5);
        add_item(OP_INSERT, 32'sh7fff_ffff);
        add_item(OP_INSERT, 32'sh8000_0000);
        add_item(OP_INSERT, 32'sh0);
        add_item(OP_INSERT, 32'sh0);
        add_item(OP_INSERT, -32'sd1);
        add_item(OP_SEARCH, 32'sh0);
        add_item(OP_SEARCH, 32'sh8000_0000);
        add_item(OP_SEARCH, 32'sh7fff_ffff);
        add_item(OP_SEARCH, 32'sd7);
        add_item(OP_DELETE, 32'sh0);
        add_item(OP_DELETE, 32'sd7);
        add_item(OP_CLEAR, 32'sh5a5a_a5a5);
        add_item(OP_SEARCH, -32'sd1);

        // random phases: fill, drain, mixed; a small value pool gives hits and duplicates
        made = 0;
        while (made < NUM_RANDOM) begin
            for (k = 0; k < 6; k++) begin
                value_pool[k] = ($urandom_range(1) == 0) ?
                    $signed(32'($urandom_range(30))) - 32'sd15 : $signed($urandom);
            end
            phase_kind = $urandom_range(2);
            phase_len  = $urandom_range(60, 20);
            case (phase_kind)
                0: begin w_ins = 72; w_del = 10; w_srch = 16; end
                1: begin w_ins = 15; w_del = 55; w_srch = 28; end
                default: begin w_ins = 40; w_del = 25; w_srch = 33; end
            endcase
            for (k = 0; k < phase_len && made < NUM_RANDOM; k++) begin
                r = $urandom_range(99);
                if (r < w_ins)                       op = OP_INSERT;
                else if (r < w_ins + w_del)          op = OP_DELETE;
                else if (r < w_ins + w_del + w_srch) op = OP_SEARCH;
                else                                 op = OP_CLEAR;
                add_item(op, pick_value());
                made++;
            end
        end

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() > 0 || i_start || expected_results.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (5) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
